### rtl/midi_file_event_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MIDI file event parser
// Shared property forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef MIDI_FILE_EVENT_PARSER_DEFINES_SVH
`define MIDI_FILE_EVENT_PARSER_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define MFEP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mfep check failed");

// next-cycle implication, off while reset is asserted
`define MFEP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mfep check failed");

`endif

### rtl/mfep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI file event parser package
// Parse phases, result kinds, result record and a status decode helper.
// ----------------------------------------------------------------------------
package mfep_pkg;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_TRACK_HDR = 4'd1,
        PH_DELTA     = 4'd2,
        PH_STATUS    = 4'd3,
        PH_DATA1     = 4'd4,
        PH_DATA2     = 4'd5,
        PH_META_TYPE = 4'd6,
        PH_META_LEN  = 4'd7,
        PH_META_DATA = 4'd8,
        PH_DONE      = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_TRACK   = 3'd1,
        KIND_TIME    = 3'd2,
        KIND_CHANNEL = 3'd3,
        KIND_TEMPO   = 3'd4
    } kind_t;

    localparam logic [7:0]  STATUS_META     = 8'hFF;
    localparam logic [7:0]  STATUS_SYSEX_END = 8'hF7;
    localparam logic [7:0]  META_TEMPO      = 8'h51;
    localparam logic [31:0] HEADER_LEN      = 32'd6;
    localparam logic [3:0]  HDR_LAST_POS    = 4'd13;
    localparam logic [3:0]  TRK_LAST_POS    = 4'd7;
    localparam logic [1:0]  TEMPO_BYTES     = 2'd3;

    typedef struct packed {
        kind_t              kind;
        logic [31:0]        tick_time;
        logic [15:0]        track_number;
        logic [3:0]         event_type;
        logic [3:0]         channel;
        logic [7:0]         first_data;
        logic [7:0]         second_data;
        logic [23:0]        tempo_us;
        logic signed [15:0] division;
        logic               header_ok;
    } result_t;

    // number of data bytes following a channel status, by upper nibble
    function automatic logic [1:0] data_count(input logic [3:0] etype);
        logic [1:0] n;
        case (etype) inside
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
            4'hC, 4'hD:                   n = 2'd1;
            default:                      n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

### rtl/mfep_parser.sv
// ----------------------------------------------------------------------------
// MIDI file event parser core
// Holds the parse state and turns one file byte per step into at most one
// result record.
// ----------------------------------------------------------------------------
module mfep_parser #(
    parameter int TIME_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              file_start,
    output logic              res_valid,
    output mfep_pkg::result_t res
);

    mfep_pkg::phase_t        phase_reg, phase_next, cur_phase;
    logic [3:0]              bpos_reg, bpos_next, cur_bpos;
    logic [31:0]             hlen_reg, hlen_next, cur_hlen;
    logic [15:0]             total_reg, total_next, cur_total;
    logic [15:0]             tidx_reg, tidx_next, cur_tidx;
    logic [31:0]             left_reg, left_next, cur_left, left_dec;
    logic [31:0]             vlq_reg, vlq_next, cur_vlq, vlq_shift;
    logic [TIME_WIDTH-1:0]   time_reg, time_next, cur_time;
    logic [7:0]              status_reg, status_next, cur_status;
    logic [7:0]              held_reg, held_next, cur_held;
    logic [7:0]              mkind_reg, mkind_next, cur_mkind;
    logic [31:0]             mleft_reg, mleft_next, cur_mleft;
    logic [23:0]             tempo_reg, tempo_next, cur_tempo;
    logic [15:0]             div_reg, div_next, cur_div;
    logic [31:0]             tick32;
    logic [15:0]             tidx_inc;
    logic                    ev_done;
    logic                    new_track;
    logic                    meta_end;

    generate
        if (TIME_WIDTH >= 32) begin : g_tick_wide
            assign tick32 = time_next[31:0];
        end else begin : g_tick_narrow
            assign tick32 = 32'(time_next);
        end
    endgenerate

    assign tidx_inc = cur_tidx + 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= mfep_pkg::PH_HEADER;
            bpos_reg   <= '0;
            hlen_reg   <= '0;
            total_reg  <= '0;
            tidx_reg   <= '0;
            left_reg   <= '0;
            vlq_reg    <= '0;
            time_reg   <= '0;
            status_reg <= '0;
            held_reg   <= '0;
            mkind_reg  <= '0;
            mleft_reg  <= '0;
            tempo_reg  <= '0;
            div_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            bpos_reg   <= bpos_next;
            hlen_reg   <= hlen_next;
            total_reg  <= total_next;
            tidx_reg   <= tidx_next;
            left_reg   <= left_next;
            vlq_reg    <= vlq_next;
            time_reg   <= time_next;
            status_reg <= status_next;
            held_reg   <= held_next;
            mkind_reg  <= mkind_next;
            mleft_reg  <= mleft_next;
            tempo_reg  <= tempo_next;
            div_reg    <= div_next;
        end
    end

    always_comb begin
        // a file start byte sees the reset state
        cur_phase  = file_start ? mfep_pkg::PH_HEADER : phase_reg;
        cur_bpos   = file_start ? '0 : bpos_reg;
        cur_hlen   = file_start ? '0 : hlen_reg;
        cur_total  = file_start ? '0 : total_reg;
        cur_tidx   = file_start ? '0 : tidx_reg;
        cur_left   = file_start ? '0 : left_reg;
        cur_vlq    = file_start ? '0 : vlq_reg;
        cur_time   = file_start ? '0 : time_reg;
        cur_status = file_start ? '0 : status_reg;
        cur_held   = file_start ? '0 : held_reg;
        cur_mkind  = file_start ? '0 : mkind_reg;
        cur_mleft  = file_start ? '0 : mleft_reg;
        cur_tempo  = file_start ? '0 : tempo_reg;
        cur_div    = file_start ? '0 : div_reg;

        // track length counts every event byte, floor at zero
        left_dec = cur_left;
        if (cur_phase inside {[mfep_pkg::PH_DELTA:mfep_pkg::PH_META_DATA]}
            && cur_left != '0) begin
            left_dec = cur_left - 32'd1;
        end

        vlq_shift   = {cur_vlq[24:0], data_byte[6:0]};

        phase_next  = cur_phase;
        bpos_next   = cur_bpos;
        hlen_next   = cur_hlen;
        total_next  = cur_total;
        tidx_next   = cur_tidx;
        left_next   = left_dec;
        vlq_next    = cur_vlq;
        time_next   = cur_time;
        status_next = cur_status;
        held_next   = cur_held;
        mkind_next  = cur_mkind;
        mleft_next  = cur_mleft;
        tempo_next  = cur_tempo;
        div_next    = cur_div;

        ev_done   = 1'b0;
        new_track = 1'b0;
        meta_end  = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        res.kind  = mfep_pkg::KIND_HEADER;

        case (cur_phase)
            mfep_pkg::PH_HEADER: begin
                if (cur_bpos inside {[4'd4:4'd7]}) begin
                    hlen_next = {cur_hlen[23:0], data_byte};
                end else if (cur_bpos inside {4'd10, 4'd11}) begin
                    total_next = {cur_total[7:0], data_byte};
                end else if (cur_bpos inside {4'd12, 4'd13}) begin
                    div_next = {cur_div[7:0], data_byte};
                end
                if (cur_bpos >= mfep_pkg::HDR_LAST_POS) begin
                    res_valid        = 1'b1;
                    res.kind         = mfep_pkg::KIND_HEADER;
                    res.division     = div_next;
                    res.header_ok    = (hlen_next == mfep_pkg::HEADER_LEN);
                    tidx_next        = '0;
                    bpos_next        = '0;
                    phase_next       = (total_next == '0) ? mfep_pkg::PH_DONE
                                                          : mfep_pkg::PH_TRACK_HDR;
                end else begin
                    bpos_next = cur_bpos + 4'd1;
                end
            end
            mfep_pkg::PH_TRACK_HDR: begin
                if (cur_bpos inside {[4'd4:4'd7]}) begin
                    left_next = {cur_left[23:0], data_byte};
                end
                if (cur_bpos >= mfep_pkg::TRK_LAST_POS) begin
                    time_next = '0;
                    res_valid = 1'b1;
                    res.kind  = mfep_pkg::KIND_TRACK;
                    bpos_next = '0;
                    if (left_next == '0) begin
                        new_track = 1'b1;
                    end else begin
                        vlq_next   = '0;
                        phase_next = mfep_pkg::PH_DELTA;
                    end
                end else begin
                    bpos_next = cur_bpos + 4'd1;
                end
            end
            mfep_pkg::PH_DELTA: begin
                vlq_next = vlq_shift;
                if (!data_byte[7]) begin
                    phase_next = mfep_pkg::PH_STATUS;
                    if (vlq_shift != '0) begin
                        time_next = cur_time + TIME_WIDTH'(vlq_shift);
                        res_valid = 1'b1;
                        res.kind  = mfep_pkg::KIND_TIME;
                    end
                end
            end
            mfep_pkg::PH_STATUS: begin
                status_next = data_byte;
                if (data_byte == mfep_pkg::STATUS_META) begin
                    phase_next = mfep_pkg::PH_META_TYPE;
                end else if (data_byte == mfep_pkg::STATUS_SYSEX_END) begin
                    ev_done = 1'b1;
                end else if (mfep_pkg::data_count(data_byte[7:4]) == 2'd0) begin
                    res_valid = 1'b1;
                    res.kind  = mfep_pkg::KIND_CHANNEL;
                    ev_done   = 1'b1;
                end else begin
                    phase_next = mfep_pkg::PH_DATA1;
                end
            end
            mfep_pkg::PH_DATA1: begin
                held_next = data_byte;
                if (mfep_pkg::data_count(cur_status[7:4]) == 2'd2) begin
                    phase_next = mfep_pkg::PH_DATA2;
                end else begin
                    res_valid      = 1'b1;
                    res.kind       = mfep_pkg::KIND_CHANNEL;
                    res.first_data = data_byte;
                    ev_done        = 1'b1;
                end
            end
            mfep_pkg::PH_DATA2: begin
                res_valid       = 1'b1;
                res.kind        = mfep_pkg::KIND_CHANNEL;
                res.first_data  = cur_held;
                res.second_data = data_byte;
                ev_done         = 1'b1;
            end
            mfep_pkg::PH_META_TYPE: begin
                mkind_next = data_byte;
                vlq_next   = '0;
                phase_next = mfep_pkg::PH_META_LEN;
            end
            mfep_pkg::PH_META_LEN: begin
                vlq_next = vlq_shift;
                if (!data_byte[7]) begin
                    mleft_next = vlq_shift;
                    tempo_next = '0;
                    bpos_next  = '0;
                    if (vlq_shift == '0) begin
                        meta_end = 1'b1;
                    end else begin
                        phase_next = mfep_pkg::PH_META_DATA;
                    end
                end
            end
            mfep_pkg::PH_META_DATA: begin
                if (cur_bpos < 4'(mfep_pkg::TEMPO_BYTES)) begin
                    case (cur_bpos[1:0])
                        2'd0:    tempo_next[23:16] = cur_tempo[23:16] | data_byte;
                        2'd1:    tempo_next[15:8]  = cur_tempo[15:8] | data_byte;
                        default: tempo_next[7:0]   = cur_tempo[7:0] | data_byte;
                    endcase
                    bpos_next = cur_bpos + 4'd1;
                end
                mleft_next = cur_mleft - 32'd1;
                if (mleft_next == '0) begin
                    meta_end = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (meta_end) begin
            if (cur_mkind == mfep_pkg::META_TEMPO) begin
                res_valid    = 1'b1;
                res.kind     = mfep_pkg::KIND_TEMPO;
                res.tempo_us = tempo_next;
            end
            ev_done = 1'b1;
        end

        if (ev_done) begin
            if (left_dec == '0) begin
                new_track = 1'b1;
            end else begin
                vlq_next   = '0;
                phase_next = mfep_pkg::PH_DELTA;
            end
        end

        if (new_track) begin
            tidx_next  = tidx_inc;
            bpos_next  = '0;
            phase_next = (tidx_inc >= cur_total) ? mfep_pkg::PH_DONE
                                                 : mfep_pkg::PH_TRACK_HDR;
        end

        res.tick_time    = tick32;
        res.track_number = cur_tidx;
        if (res.kind == mfep_pkg::KIND_CHANNEL) begin
            res.event_type = status_next[7:4];
            res.channel    = status_next[3:0];
        end
    end

endmodule

### rtl/midi_file_event_parser.sv
// ----------------------------------------------------------------------------
// MIDI file event parser
// Streams a Standard MIDI File byte by byte and emits header, track start,
// time mark, channel event and tempo items.
// ----------------------------------------------------------------------------
// One file byte is taken per clock, back to back, while the output drains. Each
// byte lands in an input register, the parser core updates its state and builds
// at most one result combinationally, and the result sits in an output register
// until taken, so a result passes the input and output registers before it is
// offered. The input side keeps flowing while a result waits, as long as the
// output register drains; a stalled output stops the input after one more byte.
// Raise the file start flag with the first byte of each file; the running tick
// count wraps at TIME_WIDTH bits and is reported in a 32-bit field.
module midi_file_event_parser #(
    parameter int TIME_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_axis_tuser,   // [0] file_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] tick_time, [47:32] track_number, [51:48] event_type,
    // [55:52] channel, [63:56] first_data, [71:64] second_data,
    // [95:72] tempo_us, [111:96] division, [112] header_ok, rest zero
    output logic [119:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser    // [2:0] kind
);

    `include "midi_file_event_parser_defines.svh"

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_start_reg;
    logic              out_valid_reg;
    mfep_pkg::result_t out_res_reg;
    logic              step;
    logic              res_valid;
    mfep_pkg::result_t res;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
    end

    mfep_parser #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .data_byte  (in_byte_reg),
        .file_start (in_start_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= res_valid;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {7'd0,
                            out_res_reg.header_ok,
                            out_res_reg.division,
                            out_res_reg.tempo_us,
                            out_res_reg.second_data,
                            out_res_reg.first_data,
                            out_res_reg.channel,
                            out_res_reg.event_type,
                            out_res_reg.track_number,
                            out_res_reg.tick_time};

    // a full input register facing a blocked output takes nothing more
    `MFEP_ASSERT_IMPL(a_in_hold, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready)
    // a byte in the input register with room downstream is consumed
    `MFEP_ASSERT_NEXT(a_in_drain, aclk, aresetn,
        in_valid_reg && !out_valid_reg && !s_axis_tvalid, !in_valid_reg)
    // header fields only travel with a header item
    `MFEP_ASSERT_IMPL(a_hdr_only, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser != mfep_pkg::KIND_HEADER,
        m_axis_tdata[112] == 1'b0 && m_axis_tdata[111:96] == '0)
    // channel fields stay zero outside channel items
    `MFEP_ASSERT_IMPL(a_chan_only, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser != mfep_pkg::KIND_CHANNEL,
        m_axis_tdata[71:48] == '0)
    // a track start restarts the tick count
    `MFEP_ASSERT_IMPL(a_track_zero, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser == mfep_pkg::KIND_TRACK,
        m_axis_tdata[31:0] == '0)

endmodule
